// ===== rtl/rbd_pkg.sv =====
// Package for the ring buffer deque: operation and status codes, and the
// structs that pass between the control logic, the memory and the top level.
// No dependencies.
package rbd_pkg;

	localparam int FuncWidth   = 3;
	localparam int WordWidth   = 32;
	localparam int StatusWidth = 2;
	localparam int OccWidth    = 5;

	typedef enum logic [FuncWidth-1:0] {
		FUNC_PUSH_BACK  = 3'd0,
		FUNC_PUSH_FRONT = 3'd1,
		FUNC_POP_BACK   = 3'd2,
		FUNC_POP_FRONT  = 3'd3,
		FUNC_PEEK_BACK  = 3'd4,
		FUNC_PEEK_FRONT = 3'd5
	} func_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		status_t             status;
		logic                is_empty;
		logic                is_full;
		logic [OccWidth-1:0] occupancy;
		logic                has_data;
	} rsp_meta_t;

endpackage

// ===== rtl/rbd_ifs.sv =====
// Valid/ready channel interfaces for the ring buffer deque: the operation
// request channel and the result channel. Depends on rbd_pkg.
interface rbd_req_if import rbd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FuncWidth-1:0] func;
	logic [WordWidth-1:0] push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink (input valid, input func, input push_value, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [WordWidth-1:0]   read_value;
	logic [StatusWidth-1:0] status;
	logic                   is_empty;
	logic                   is_full;
	logic [OccWidth-1:0]    occupancy;

	modport source (output valid, output read_value, output status, output is_empty,
		output is_full, output occupancy, input ready);
	modport sink (input valid, input read_value, input status, input is_empty,
		input is_full, input occupancy, output ready);
endinterface

// ===== rtl/ring_buffer_deque.sv =====
// Ring buffer deque: a double-ended queue of DEPTH words of DATA_WIDTH bits in
// one synchronous memory, with push, pop and peek at either end. It takes one
// word per cycle while the result channel does not stall; each result passes
// through the registered memory read and then an output register, so a new
// word is accepted while an earlier result waits to be taken. Indices
// and occupancy update at acceptance, so consecutive words never conflict.
// Depends on rbd_pkg, rbd_ifs, rbd_ctrl and rbd_mem.
module ring_buffer_deque import rbd_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	rbd_req_if.sink  req,
	rbd_rsp_if.source rsp
);

	localparam int IW = $clog2(DEPTH);

	logic                  accept, adv_s1, valid_s1, rsp_valid_q;
	mem_ctl_t              mem_ctl;
	logic [IW-1:0]         mem_addr;
	logic [DATA_WIDTH-1:0] rdata;
	rsp_meta_t             meta, meta_s1, meta_q;
	logic [WordWidth-1:0]  value_q;

	assign adv_s1    = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | adv_s1;
	assign accept    = req.valid & req.ready;

	rbd_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (req.func),
		.mem_ctl  (mem_ctl),
		.mem_addr (mem_addr),
		.meta     (meta)
	);

	rbd_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (DATA_WIDTH'(req.push_value)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
		if (adv_s1) begin
			meta_q  <= meta_s1;
			value_q <= meta_s1.has_data ? WordWidth'(rdata) : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = value_q;
	assign rsp.status     = meta_q.status;
	assign rsp.is_empty   = meta_q.is_empty;
	assign rsp.is_full    = meta_q.is_full;
	assign rsp.occupancy  = meta_q.occupancy;

endmodule

// ===== rtl/rbd_mem.sv =====
// Slot store of the ring buffer deque: one synchronous memory with one
// read/write port and a registered read. Depends on rbd_pkg.
module rbd_mem import rbd_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  mem_ctl_t                 ctl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	output logic [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/rbd_ctrl.sv =====
// Index and occupancy control of the ring buffer deque: decodes each word,
// steps the front and back indices and the count, and drives the memory.
// Depends on rbd_pkg.
module rbd_ctrl import rbd_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [FuncWidth-1:0]     func,
	output mem_ctl_t                 mem_ctl,
	output logic [$clog2(DEPTH)-1:0] mem_addr,
	output rsp_meta_t                meta
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	logic [IW-1:0] front_q, back_q, front_d, back_d;
	logic [CW-1:0] count_q, count_d;
	logic          empty, full;
	logic [31:0]   count_wide;
	mem_ctl_t      ctl;
	status_t       status;

	function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
		return (i == LastIdx) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
		return (i == '0) ? LastIdx : i - IW'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == FullCnt);

	always_comb begin
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		ctl      = '0;
		mem_addr = front_q;
		status   = ST_DONE;
		case (func)
			FUNC_PUSH_BACK: begin
				if (full) begin
					status = ST_REJECT;
				end else begin
					ctl.wr_en = 1'b1;
					mem_addr  = back_q;
					back_d    = idx_next(back_q);
					count_d   = count_q + CW'(1);
				end
			end
			FUNC_PUSH_FRONT: begin
				if (full) begin
					status = ST_REJECT;
				end else begin
					ctl.wr_en = 1'b1;
					mem_addr  = idx_prev(front_q);
					front_d   = idx_prev(front_q);
					count_d   = count_q + CW'(1);
				end
			end
			FUNC_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rd_en = 1'b1;
					mem_addr  = idx_prev(back_q);
					back_d    = idx_prev(back_q);
					count_d   = count_q - CW'(1);
				end
			end
			FUNC_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rd_en = 1'b1;
					mem_addr  = front_q;
					front_d   = idx_next(front_q);
					count_d   = count_q - CW'(1);
				end
			end
			FUNC_PEEK_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rd_en = 1'b1;
					mem_addr  = idx_prev(back_q);
				end
			end
			FUNC_PEEK_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctl.rd_en = 1'b1;
					mem_addr  = front_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_ctl.wr_en = accept & ctl.wr_en;
	assign mem_ctl.rd_en = accept & ctl.rd_en;

	assign count_wide     = 32'(count_d);
	assign meta.status    = status;
	assign meta.is_empty  = (count_d == '0);
	assign meta.is_full   = (count_d == FullCnt);
	assign meta.occupancy = count_wide[OccWidth-1:0];
	assign meta.has_data  = ctl.rd_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ring_buffer_deque: a directed table, then random
// words with random gaps on both channels, checked against a deque predictor.
// Depends on rbd_pkg, rbd_ifs and the ring_buffer_deque RTL.
module tb_top import rbd_pkg::*;;

	localparam int DEPTH = 16;
	localparam int IdxWidth = $clog2(DEPTH);
	localparam logic [OccWidth-1:0] FULL_OCC = OccWidth'(DEPTH);
	localparam logic [FuncWidth-1:0] FUNC_NOP6 = 3'd6;
	localparam logic [FuncWidth-1:0] FUNC_NOP7 = 3'd7;
	localparam int RANDOM_WORDS = 1800;
	localparam int LONG_HOLD = 80;
	localparam int DRAIN_SLACK = 10;

	typedef struct packed {
		logic [WordWidth-1:0] read_value;
		status_t              status;
		logic                 is_empty;
		logic                 is_full;
		logic [OccWidth-1:0]  occupancy;
	} deque_result_t;

	typedef struct {
		logic [FuncWidth-1:0] func;
		logic [WordWidth-1:0] word;
		int                   reps;
		bit                   use_lit;
		logic [WordWidth-1:0] lit_value;
		status_t              lit_status;
		logic [OccWidth-1:0]  lit_occ;
	} script_row_t;

	script_row_t script [21] = '{
		'{FUNC_POP_BACK,   32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY,  5'd0},
		'{FUNC_PEEK_FRONT, 32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY,  5'd0},
		'{FUNC_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY,  5'd0},
		'{FUNC_PEEK_BACK,  32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY,  5'd0},
		'{FUNC_NOP6,       32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_DONE,   5'd0},
		'{FUNC_NOP7,       32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_DONE,   5'd0},
		'{FUNC_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, 32'h0, ST_DONE,   5'd1},
		'{FUNC_PUSH_FRONT, 32'h0000_0000,  1, 1'b1, 32'h0, ST_DONE,   5'd2},
		'{FUNC_PEEK_BACK,  32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_PEEK_FRONT, 32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_POP_FRONT,  32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_POP_BACK,   32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_PUSH_FRONT, 32'h8000_0000, 16, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_PUSH_BACK,  32'h5555_5555,  1, 1'b1, 32'h0, ST_REJECT, 5'd16},
		'{FUNC_PUSH_FRONT, 32'hAAAA_AAAA,  1, 1'b1, 32'h0, ST_REJECT, 5'd16},
		'{FUNC_PEEK_BACK,  32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_PEEK_FRONT, 32'h0000_0000,  1, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_POP_BACK,   32'h0000_0000, 16, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0, ST_EMPTY,  5'd0},
		'{FUNC_PUSH_BACK,  32'h7FFF_FFF0, 20, 1'b0, 32'h0, ST_DONE,   5'd0},
		'{FUNC_POP_FRONT,  32'h0000_0000, 20, 1'b0, 32'h0, ST_DONE,   5'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	rbd_req_if req_ch ();
	rbd_rsp_if rsp_ch ();

	ring_buffer_deque #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(WordWidth)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [WordWidth-1:0] shadow_slots [DEPTH];
	logic [IdxWidth-1:0]  head_idx = '0;
	logic [IdxWidth-1:0]  tail_idx = '0;
	logic [OccWidth-1:0]  fill_count = '0;
	deque_result_t        expected_q [$];
	int                   mismatch_count = 0;
	bit                   long_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic deque_result_t apply_op(input logic [FuncWidth-1:0] f,
		input logic [WordWidth-1:0] word);
		deque_result_t       res;
		logic [IdxWidth-1:0] last_idx;
		res.read_value = '0;
		res.status = ST_DONE;
		last_idx = tail_idx - 1'b1;
		case (f)
			FUNC_PUSH_BACK: begin
				if (fill_count == FULL_OCC) begin
					res.status = ST_REJECT;
				end else begin
					shadow_slots[tail_idx] = word;
					tail_idx = tail_idx + 1'b1;
					fill_count = fill_count + 1'b1;
				end
			end
			FUNC_PUSH_FRONT: begin
				if (fill_count == FULL_OCC) begin
					res.status = ST_REJECT;
				end else begin
					head_idx = head_idx - 1'b1;
					shadow_slots[head_idx] = word;
					fill_count = fill_count + 1'b1;
				end
			end
			FUNC_POP_BACK: begin
				if (fill_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					tail_idx = last_idx;
					res.read_value = shadow_slots[tail_idx];
					fill_count = fill_count - 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (fill_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = shadow_slots[head_idx];
					head_idx = head_idx + 1'b1;
					fill_count = fill_count - 1'b1;
				end
			end
			FUNC_PEEK_BACK: begin
				if (fill_count == 0)
					res.status = ST_EMPTY;
				else
					res.read_value = shadow_slots[last_idx];
			end
			FUNC_PEEK_FRONT: begin
				if (fill_count == 0)
					res.status = ST_EMPTY;
				else
					res.read_value = shadow_slots[head_idx];
			end
			default: begin
			end
		endcase
		res.is_empty = (fill_count == 0);
		res.is_full = (fill_count == FULL_OCC);
		res.occupancy = fill_count;
		return res;
	endfunction

	task automatic send_word(input logic [FuncWidth-1:0] f, input logic [WordWidth-1:0] word,
		input bit use_lit, input deque_result_t lit);
		deque_result_t res;
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.push_value <= word;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		res = apply_op(f, word);
		expected_q.push_back(use_lit ? lit : res);
	endtask

	task automatic idle_sender();
		int gap;
		gap = long_hold_req ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		deque_result_t        lit;
		logic [FuncWidth-1:0] f;
		logic [WordWidth-1:0] word;
		int                   sent;
		int                   push_pct;
		int                   r;
		bit                   hold_done;
		bit                   drain_done;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.push_value = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			lit.read_value = script[i].lit_value;
			lit.status = script[i].lit_status;
			lit.is_empty = (script[i].lit_occ == 0);
			lit.is_full = (script[i].lit_occ == FULL_OCC);
			lit.occupancy = script[i].lit_occ;
			for (int k = 0; k < script[i].reps; k++) begin
				send_word(script[i].func, script[i].word + WordWidth'(k), script[i].use_lit,
					lit);
				idle_sender();
			end
		end

		sent = 0;
		push_pct = 50;
		hold_done = 1'b0;
		drain_done = 1'b0;
		lit = '0;
		while (sent < RANDOM_WORDS) begin
			if (sent % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 50;
					1: push_pct = 75;
					default: push_pct = 25;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 3) begin
				f = $urandom_range(0, 1) ? FUNC_NOP7 : FUNC_NOP6;
			end else if ($urandom_range(0, 99) < push_pct) begin
				f = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
			end else begin
				case ($urandom_range(0, 3))
					0: f = FUNC_POP_BACK;
					1: f = FUNC_POP_FRONT;
					2: f = FUNC_PEEK_BACK;
					default: f = FUNC_PEEK_FRONT;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 10)
				word = '0;
			else if (r < 20)
				word = '1;
			else
				word = $urandom;
			send_word(f, word, 1'b0, lit);
			sent++;

			if (sent >= 600 && !hold_done) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (sent >= 1200 && !drain_done) begin
				req_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (expected_q.size() != 0);
				drain_done = 1'b1;
			end else begin
				idle_sender();
			end
		end

		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_q.size() != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected word: value %h status %0d empty %b full %b occ %0d",
						rsp_ch.read_value, rsp_ch.status, rsp_ch.is_empty, rsp_ch.is_full,
						rsp_ch.occupancy);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.read_value !== want.read_value || rsp_ch.status !== want.status ||
					rsp_ch.is_empty !== want.is_empty || rsp_ch.is_full !== want.is_full ||
					rsp_ch.occupancy !== want.occupancy) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"Mismatch: expected value %h status %0d empty %b full %b ",
							"occ %0d, got value %h status %0d empty %b full %b occ %0d"},
							want.read_value, want.status, want.is_empty, want.is_full,
							want.occupancy, rsp_ch.read_value, rsp_ch.status,
							rsp_ch.is_empty, rsp_ch.is_full, rsp_ch.occupancy);
				end
			end
		end
	end

endmodule

// ===== ring_buffer_deque.f =====
rtl/rbd_pkg.sv
rtl/rbd_ifs.sv
rtl/rbd_mem.sv
rtl/rbd_ctrl.sv
rtl/ring_buffer_deque.sv
tb/tb_top.sv
